[src/bta_pkg.sv]
`timescale 1ns / 1ps
package bta_pkg;

	localparam int HEAP_WORDS_DEF = 65536;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_ZERO = 2'd1;
	localparam logic [1:0] ST_OOM  = 2'd2;

	localparam logic [18:0] INIT_GROW   = 19'd4096;
	localparam logic [31:0] MIN_BLOCK   = 32'd16;
	localparam logic [31:0] FIRST_BP    = 32'd24;
	localparam logic [31:0] PROLOGUE_BP = 32'd8;
	localparam logic [31:0] PROLOGUE_TAG = 32'd17;
	localparam logic [31:0] ALLOC_TAG    = 32'd1;

	// size field of a boundary tag
	function automatic logic [31:0] tag_size(input logic [31:0] w);
		tag_size = {w[31:3], 3'b000};
	endfunction

endpackage

[src/boundary_tag_heap_allocator_top.sv]
`timescale 1ns / 1ps
// boundary-tag heap allocator, first fit over an explicit lifo free list
//
// input channel s_*: one item per request. s_tuser[0] is the request kind
// (0 allocate, 1 free); s_tdata carries the byte count and the release address.
// output channel m_*: exactly one item per request with the payload offset
// and a status code (ok, zero size, out of memory).
// cfg_we / cfg_wdata set the minimum growth chunk; write only while idle.
//
// each request runs on one sequencer around a single-port heap memory with a
// registered read, one tag or link access per cycle. a free is either ignored or
// merged with its free neighbors, depending on the merge case; an allocate
// walks the free list block by block, grows the heap when no block fits, then
// places and splits the block found. s_tready is high only while
// the sequencer is idle.
// after reset the block clears the heap, one word per cycle, writes the prologue
// and epilogue and grows the first free block; no item is taken until then.
// cfg writes are taken at any time.
// a finished result sits in the output register; if the receiver stalls, the
// next request is accepted but its result waits until the register is empty.
// HEAP_WORDS must be a power of two.
module boundary_tag_heap_allocator_top #(
	parameter int HEAP_WORDS = bta_pkg::HEAP_WORDS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // request_bytes[18:0], release_addr[36:19], zero fill
	input  logic [0:0]  s_tuser,   // req_type
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // payload_addr[17:0], status[19:18], zero fill
	input  logic        cfg_we,
	input  logic [18:0] cfg_wdata
);
	import bta_pkg::*;

	localparam int IW = $clog2(HEAP_WORDS);
	localparam int AW = IW + 2;                 // byte address bits
	localparam int BW = AW + 1;                 // heap break holds the full size
	localparam int LIMIT = HEAP_WORDS / 4 + 2;  // list walk bound
	localparam int CW = $clog2(LIMIT + 1);
	localparam logic [33:0] HEAP_BYTES = 34'(HEAP_WORDS) * 34'd4;

	// sequencer states
	localparam logic [5:0] S_CLR = 6'd0, S_IDLE = 6'd1, S_FF_RD = 6'd2, S_FF_CHK = 6'd3,
		S_FF_NX = 6'd4, S_NOFIT = 6'd5, S_GROW = 6'd6, S_G2 = 6'd7, S_G3 = 6'd8,
		S_GROW_DONE = 6'd9, S_EV0 = 6'd10, S_EV1 = 6'd11, S_EV2 = 6'd12, S_EV3 = 6'd13,
		S_EV4 = 6'd14, S_MG_BR = 6'd15, S_MG_PA = 6'd16, S_MG_NA = 6'd17, S_MG_N2 = 6'd18,
		S_MG_NS = 6'd19, S_MG_T1 = 6'd20, S_MG_T2 = 6'd21, S_MG_END = 6'd22, S_PU0 = 6'd23,
		S_PU1 = 6'd24, S_PU2 = 6'd25, S_UL0 = 6'd26, S_UL1 = 6'd27, S_UL_H = 6'd28,
		S_UL2 = 6'd29, S_UL3 = 6'd30, S_PL0 = 6'd31, S_PL1 = 6'd32, S_PL2 = 6'd33,
		S_PL3 = 6'd34, S_PL4 = 6'd35, S_PL5 = 6'd36, S_PL6 = 6'd37, S_PL_DONE = 6'd38,
		S_FR0 = 6'd39, S_FR1 = 6'd40, S_FR2 = 6'd41, S_FIN = 6'd42;

	logic [5:0]  state_q, eval_ret_q, unlink_ret_q, push_ret_q, merge_ret_q;
	logic        init_q;
	logic [18:0] chunk_q;
	logic [IW-1:0] clr_q;
	logic [CW-1:0] cnt_q;
	logic [BW-1:0] brk_q;
	logic [31:0] head_q, bp_q, pb_q, ub_q, asize_q, gsize_q, size_q, csize_q, rem_q;
	logic [31:0] succ_q, pred_q;
	logic [31:0] ev_prev_q, ev_psize_q, ev_next_q, ev_nsize_q, ev_size_q;
	logic        ev_pa_q, ev_na_q;
	logic [17:0] res_addr_q, out_addr_q;
	logic [1:0]  res_st_q, out_st_q;
	logic        ovalid_q;

	// heap memory, one access per cycle
	logic [31:0] heap_mem [HEAP_WORDS];
	logic [31:0] rdata_q;
	logic [31:0] mem_addr, mem_wdata;
	logic        mem_we;
	logic [IW-1:0] mem_idx;

	logic [31:0] rsize, prev_c, next_c, pb_c, brk32;
	logic [33:0] grow_end;
	logic [19:0] req_round;
	logic        grow_ok;

	assign rsize    = tag_size(rdata_q);
	assign prev_c   = bp_q - rsize;
	assign next_c   = bp_q + rsize;
	assign pb_c     = bp_q + asize_q;
	assign brk32    = {{(32-BW){1'b0}}, brk_q};
	assign grow_end = {{(34-BW){1'b0}}, brk_q} + {2'b00, gsize_q};
	assign grow_ok  = grow_end <= HEAP_BYTES;
	assign req_round = {1'b0, s_tdata[18:0]} + 20'd15;

	always_comb begin
		mem_addr  = '0;
		mem_wdata = '0;
		mem_we    = 1'b0;
		case (state_q)
			S_FF_RD:  mem_addr = bp_q - 32'd4;
			S_FF_CHK: mem_addr = bp_q + 32'd4;
			S_GROW: begin
				mem_addr = brk32 - 32'd4; mem_wdata = gsize_q; mem_we = grow_ok;
			end
			S_G2: begin
				mem_addr = bp_q + gsize_q - 32'd8; mem_wdata = gsize_q; mem_we = 1'b1;
			end
			S_G3: begin
				mem_addr = bp_q + gsize_q - 32'd4; mem_wdata = ALLOC_TAG; mem_we = 1'b1;
			end
			S_EV0: mem_addr = bp_q - 32'd8;
			S_EV1: mem_addr = prev_c - 32'd4;
			S_EV2: mem_addr = bp_q - 32'd4;
			S_EV3: mem_addr = next_c - 32'd4;
			S_MG_T1: begin
				mem_addr = bp_q - 32'd4; mem_wdata = size_q; mem_we = 1'b1;
			end
			S_MG_T2: begin
				mem_addr = bp_q + size_q - 32'd8; mem_wdata = size_q; mem_we = 1'b1;
			end
			S_PU0: begin
				mem_addr = pb_q + 32'd4; mem_wdata = head_q; mem_we = 1'b1;
			end
			S_PU1: begin
				mem_addr = pb_q; mem_we = 1'b1;
			end
			S_PU2: begin
				mem_addr = head_q; mem_wdata = pb_q; mem_we = 1'b1;
			end
			S_UL0: mem_addr = ub_q + 32'd4;
			S_UL1: mem_addr = ub_q;
			S_UL_H: begin
				mem_addr = succ_q; mem_we = 1'b1;
			end
			S_UL2: begin
				mem_addr = rdata_q + 32'd4; mem_wdata = succ_q; mem_we = 1'b1;
			end
			S_UL3: begin
				mem_addr = succ_q; mem_wdata = pred_q; mem_we = 1'b1;
			end
			S_PL0: mem_addr = bp_q - 32'd4;
			S_PL2: begin
				mem_addr = bp_q - 32'd4; mem_we = 1'b1;
				mem_wdata = ((csize_q - asize_q) >= MIN_BLOCK) ? (asize_q | ALLOC_TAG)
					: (csize_q | ALLOC_TAG);
			end
			S_PL3: begin
				mem_addr = bp_q + asize_q - 32'd8; mem_wdata = asize_q | ALLOC_TAG;
				mem_we = 1'b1;
			end
			S_PL4: begin
				mem_addr = pb_q - 32'd4; mem_wdata = rem_q; mem_we = 1'b1;
			end
			S_PL5: begin
				mem_addr = pb_q + rem_q - 32'd8; mem_wdata = rem_q; mem_we = 1'b1;
			end
			S_PL6: begin
				mem_addr = bp_q + csize_q - 32'd8; mem_wdata = csize_q | ALLOC_TAG;
				mem_we = 1'b1;
			end
			S_FR0: mem_addr = bp_q - 32'd4;
			S_FR1: begin
				mem_addr = bp_q - 32'd4; mem_wdata = rsize; mem_we = rdata_q[0];
			end
			S_FR2: begin
				mem_addr = bp_q + size_q - 32'd8; mem_wdata = size_q; mem_we = 1'b1;
			end
			S_CLR: begin
				mem_we = 1'b1;
				// prologue tags at words 1 and 4, epilogue at word 5
				if (clr_q == IW'(1) || clr_q == IW'(4)) begin
					mem_wdata = PROLOGUE_TAG;
				end else if (clr_q == IW'(5)) begin
					mem_wdata = ALLOC_TAG;
				end
			end
			default: mem_we = 1'b0;
		endcase
		mem_idx = (state_q == S_CLR) ? clr_q : mem_addr[AW-1:2];
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			heap_mem[mem_idx] <= mem_wdata;
		end
		rdata_q <= heap_mem[mem_idx];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLR;
			eval_ret_q   <= S_IDLE;
			unlink_ret_q <= S_IDLE;
			push_ret_q   <= S_IDLE;
			merge_ret_q  <= S_IDLE;
			init_q       <= 1'b1;
			chunk_q      <= INIT_GROW;
			clr_q        <= '0;
			cnt_q        <= '0;
			brk_q        <= BW'(FIRST_BP);
			head_q       <= PROLOGUE_BP;
			ovalid_q     <= 1'b0;
		end else begin
			if (cfg_we) begin
				chunk_q <= cfg_wdata;
			end
			if (ovalid_q && m_tready) begin
				ovalid_q <= 1'b0;
			end
			case (state_q)
				S_CLR: begin
					clr_q <= clr_q + IW'(1);
					if (clr_q == IW'(HEAP_WORDS - 1)) begin
						gsize_q <= {13'd0, INIT_GROW};
						state_q <= S_GROW;
					end
				end
				S_IDLE: begin
					if (s_tvalid) begin
						if (s_tuser[0]) begin
							bp_q    <= {14'd0, s_tdata[36:19]};
							state_q <= S_FR0;
						end else if (s_tdata[18:0] == 19'd0) begin
							res_addr_q <= '0;
							res_st_q   <= ST_ZERO;
							state_q    <= S_FIN;
						end else begin
							asize_q <= (s_tdata[18:0] <= 19'd8) ? MIN_BLOCK
								: {12'd0, req_round[19:3], 3'b000};
							bp_q    <= head_q;
							cnt_q   <= '0;
							state_q <= S_FF_RD;
						end
					end
				end
				// first-fit walk
				S_FF_RD: state_q <= (cnt_q == CW'(LIMIT)) ? S_NOFIT : S_FF_CHK;
				S_FF_CHK: begin
					if (rdata_q[0]) begin
						state_q <= S_NOFIT;
					end else if (rsize >= asize_q) begin
						state_q <= S_PL0;
					end else begin
						state_q <= S_FF_NX;
					end
				end
				S_FF_NX: begin
					bp_q    <= rdata_q;
					cnt_q   <= cnt_q + CW'(1);
					state_q <= S_FF_RD;
				end
				S_NOFIT: begin
					gsize_q <= (asize_q > {13'd0, chunk_q[18:3], 3'b000}) ? asize_q
						: {13'd0, chunk_q[18:3], 3'b000};
					state_q <= S_GROW;
				end
				// heap growth
				S_GROW: begin
					if (grow_ok) begin
						bp_q    <= brk32;
						brk_q   <= grow_end[BW-1:0];
						state_q <= S_G2;
					end else if (init_q) begin
						init_q  <= 1'b0;
						state_q <= S_IDLE;
					end else begin
						res_addr_q <= '0;
						res_st_q   <= ST_OOM;
						state_q    <= S_FIN;
					end
				end
				S_G2: state_q <= S_G3;
				S_G3: begin
					merge_ret_q <= S_GROW_DONE;
					eval_ret_q  <= S_MG_BR;
					state_q     <= S_EV0;
				end
				S_GROW_DONE: begin
					if (init_q) begin
						init_q  <= 1'b0;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_PL0;
					end
				end
				// neighbor evaluation around bp
				S_EV0: state_q <= S_EV1;
				S_EV1: begin
					ev_prev_q <= prev_c;
					state_q   <= S_EV2;
				end
				S_EV2: begin
					ev_psize_q <= rsize;
					ev_pa_q    <= rdata_q[0];
					state_q    <= S_EV3;
				end
				S_EV3: begin
					ev_size_q <= rsize;
					ev_next_q <= next_c;
					state_q   <= S_EV4;
				end
				S_EV4: begin
					ev_nsize_q <= rsize;
					ev_na_q    <= rdata_q[0];
					state_q    <= eval_ret_q;
				end
				// coalescing, four cases
				S_MG_BR: begin
					size_q <= ev_size_q;
					if (ev_pa_q && ev_na_q) begin
						pb_q       <= bp_q;
						push_ret_q <= S_MG_END;
						state_q    <= S_PU0;
					end else begin
						ub_q         <= ev_pa_q ? ev_next_q : ev_prev_q;
						unlink_ret_q <= S_EV0;
						eval_ret_q   <= ev_pa_q ? S_MG_PA : (ev_na_q ? S_MG_NA : S_MG_N2);
						state_q      <= S_UL0;
					end
				end
				S_MG_PA: begin
					size_q  <= size_q + ev_nsize_q;
					state_q <= S_MG_T1;
				end
				S_MG_NA: begin
					size_q  <= size_q + ev_psize_q;
					bp_q    <= ev_prev_q;
					state_q <= S_MG_T1;
				end
				S_MG_N2: begin
					ub_q         <= ev_next_q;
					unlink_ret_q <= S_EV0;
					eval_ret_q   <= S_MG_NS;
					state_q      <= S_UL0;
				end
				S_MG_NS: begin
					size_q  <= size_q + ev_nsize_q + ev_psize_q;
					bp_q    <= ev_prev_q;
					state_q <= S_MG_T1;
				end
				S_MG_T1: state_q <= S_MG_T2;
				S_MG_T2: begin
					pb_q       <= bp_q;
					push_ret_q <= S_MG_END;
					state_q    <= S_PU0;
				end
				S_MG_END: state_q <= merge_ret_q;
				// list push at head
				S_PU0: state_q <= S_PU1;
				S_PU1: state_q <= S_PU2;
				S_PU2: begin
					head_q  <= pb_q;
					state_q <= push_ret_q;
				end
				// list unlink
				S_UL0: state_q <= S_UL1;
				S_UL1: begin
					succ_q  <= rdata_q;
					state_q <= (ub_q == head_q) ? S_UL_H : S_UL2;
				end
				S_UL_H: begin
					head_q  <= succ_q;
					state_q <= unlink_ret_q;
				end
				S_UL2: begin
					pred_q  <= rdata_q;
					state_q <= S_UL3;
				end
				S_UL3: state_q <= unlink_ret_q;
				// place with optional split
				S_PL0: state_q <= S_PL1;
				S_PL1: begin
					csize_q      <= rsize;
					ub_q         <= bp_q;
					unlink_ret_q <= S_PL2;
					state_q      <= S_UL0;
				end
				S_PL2: begin
					rem_q   <= csize_q - asize_q;
					state_q <= ((csize_q - asize_q) >= MIN_BLOCK) ? S_PL3 : S_PL6;
				end
				S_PL3: begin
					pb_q    <= pb_c;
					state_q <= S_PL4;
				end
				S_PL4: state_q <= S_PL5;
				S_PL5: begin
					push_ret_q <= S_PL_DONE;
					state_q    <= S_PU0;
				end
				S_PL6: state_q <= S_PL_DONE;
				S_PL_DONE: begin
					res_addr_q <= bp_q[17:0];
					res_st_q   <= ST_OK;
					state_q    <= S_FIN;
				end
				// free request
				S_FR0: begin
					res_addr_q <= '0;
					res_st_q   <= ST_OK;
					if (bp_q >= FIRST_BP && bp_q[2:0] == 3'b000 && bp_q < brk32) begin
						state_q <= S_FR1;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_FR1: begin
					size_q  <= rsize;
					state_q <= rdata_q[0] ? S_FR2 : S_FIN;
				end
				S_FR2: begin
					merge_ret_q <= S_FIN;
					eval_ret_q  <= S_MG_BR;
					state_q     <= S_EV0;
				end
				S_FIN: begin
					if (!ovalid_q) begin
						out_addr_q <= res_addr_q;
						out_st_q   <= res_st_q;
						ovalid_q   <= 1'b1;
						state_q    <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = ovalid_q;
	assign m_tdata  = {4'd0, out_st_q, out_addr_q};

endmodule
